@@ rtl/cartridge_bank_controller_core_defines.svh @@
// ----------------------------------------------------------------------------
// Cartridge bank controller assertion macros
// Shared assertion wrappers; defining ASSERT_OFF removes every check.
// ----------------------------------------------------------------------------
`ifndef CARTRIDGE_BANK_CONTROLLER_CORE_DEFINES_SVH
`define CARTRIDGE_BANK_CONTROLLER_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
// Clocked check that is suspended while reset is asserted.
`define CBC_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Clocked check that also holds during reset.
`define CBC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CBC_ASSERT(lbl, clk, rst, prop, msg)
`define CBC_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

@@ rtl/cbc_pkg.sv @@
// ----------------------------------------------------------------------------
// Cartridge bank controller package
// Controller kind codes, field widths and the bank state record.
// ----------------------------------------------------------------------------
package cbc_pkg;

  localparam int unsigned ADDR_W     = 15;
  localparam int unsigned DATA_W     = 8;
  localparam int unsigned ROM_BANK_W = 9;
  localparam int unsigned RAM_BANK_W = 4;
  localparam int unsigned KIND_W     = 3;
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;

  // Controller kind codes; any other code behaves as no controller.
  localparam logic [KIND_W-1:0] KIND_NONE = 3'd0;
  localparam logic [KIND_W-1:0] KIND_MBC1 = 3'd1;
  localparam logic [KIND_W-1:0] KIND_MBC2 = 3'd2;
  localparam logic [KIND_W-1:0] KIND_MBC3 = 3'd3;
  localparam logic [KIND_W-1:0] KIND_MBC5 = 3'd4;

  // Register index of controller_kind.
  localparam logic REG_KIND = 1'b0;

  // Address regions of the ROM window, taken from address bits 14:13.
  localparam logic [1:0] REGION_ENABLE = 2'd0;
  localparam logic [1:0] REGION_ROM    = 2'd1;
  localparam logic [1:0] REGION_HIGH   = 2'd2;
  localparam logic [1:0] REGION_MODE   = 2'd3;

  localparam logic [3:0] RAM_ENABLE_KEY = 4'hA;
  localparam logic [DATA_W-1:0] LATCH_ARM  = 8'h00;
  localparam logic [DATA_W-1:0] LATCH_FIRE = 8'h01;

  typedef struct packed {
    logic                  ram_en;
    logic [ROM_BANK_W-1:0] rom_bank;
    logic [RAM_BANK_W-1:0] ram_bank;
    logic                  mode;
    logic                  armed;
    logic                  latched;
  } cbc_state_t;

  localparam cbc_state_t STATE_RESET = '{
    ram_en:   1'b0,
    rom_bank: 9'd1,
    ram_bank: 4'd0,
    mode:     1'b0,
    armed:    1'b0,
    latched:  1'b0
  };

endpackage

@@ rtl/cbc_channels.sv @@
// ----------------------------------------------------------------------------
// Cartridge bank controller channels
// Valid/ready channels for CPU writes and for bank status results.
// ----------------------------------------------------------------------------
interface cbc_wr_if;
  import cbc_pkg::*;

  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] write_address;
  logic [DATA_W-1:0] write_data;

  modport source (output valid, output write_address, output write_data, input ready);
  modport sink   (input valid, input write_address, input write_data, output ready);
endinterface

interface cbc_res_if;
  import cbc_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [ROM_BANK_W-1:0] rom_bank_now;
  logic [RAM_BANK_W-1:0] ram_bank_now;
  logic                  ram_enabled;
  logic                  banking_mode;
  logic                  clock_latched;
  logic                  ram_flush;

  modport source (output valid, output rom_bank_now, output ram_bank_now,
                  output ram_enabled, output banking_mode, output clock_latched,
                  output ram_flush, input ready);
  modport sink   (input valid, input rom_bank_now, input ram_bank_now,
                  input ram_enabled, input banking_mode, input clock_latched,
                  input ram_flush, output ready);
endinterface

@@ rtl/cartridge_bank_controller_core.sv @@
// ----------------------------------------------------------------------------
// Cartridge bank controller core
// Decodes CPU writes to the cartridge ROM window into bank selection state.
// ----------------------------------------------------------------------------
//   Channel   Direction  Handshake      Carries
//   wr        in         valid/ready    write_address, write_data
//   res       out        valid/ready    bank state after the write, ram_flush
//   APB       in         psel/penable   controller_kind register at byte 0
//
// A write is captured in an input register and, once the result register can
// take it, is decoded against the bank state into the result register, whose
// valid flag drives res.valid; the result is held until res.ready takes it.
// One write is accepted per cycle while res.ready is high; the decode of the
// held write against the bank state sets that rate.
// When res stalls, the input register keeps one more write and then wr.ready
// drops. Reset puts RAM enable off, ROM bank 1, RAM bank 0, ROM banking mode,
// clock unlatched and the kind register at none.
// ----------------------------------------------------------------------------
`include "cartridge_bank_controller_core_defines.svh"

module cartridge_bank_controller_core (
  input  logic                          clk,
  input  logic                          rst,
  cbc_wr_if.sink                        wr,
  cbc_res_if.source                     res,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cbc_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [cbc_pkg::APB_DATA_W-1:0] pwdata,
  output logic [cbc_pkg::APB_DATA_W-1:0] prdata,
  output logic                          pready
);
  import cbc_pkg::*;

  logic [KIND_W-1:0] kind;
  logic              in_vld;
  logic [ADDR_W-1:0] in_addr;
  logic [DATA_W-1:0] in_data;
  cbc_state_t        state;
  cbc_state_t        state_next;
  logic              flush;
  logic              out_vld;
  logic              advance;
  logic              step;
  logic              accept;

  cbc_apb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .kind    (kind)
  );

  cbc_decode u_decode (
    .kind       (kind),
    .addr       (in_addr),
    .data       (in_data),
    .state      (state),
    .state_next (state_next),
    .flush      (flush)
  );

  assign advance  = !out_vld || res.ready;
  assign step     = in_vld && advance;
  assign wr.ready = !in_vld || advance;
  assign accept   = wr.valid && wr.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (accept) begin
      in_vld <= 1'b1;
    end else if (advance) begin
      in_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_addr <= wr.write_address;
      in_data <= wr.write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= STATE_RESET;
      out_vld <= 1'b0;
    end else begin
      if (step) begin
        state <= state_next;
      end
      if (advance) begin
        out_vld <= in_vld;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res.rom_bank_now  <= state_next.rom_bank;
      res.ram_bank_now  <= state_next.ram_bank;
      res.ram_enabled   <= state_next.ram_en;
      res.banking_mode  <= state_next.mode;
      res.clock_latched <= state_next.latched;
      res.ram_flush     <= flush;
    end
  end

  assign res.valid = out_vld;

  `CBC_ASSERT(a_state_moves_on_step, clk, rst, !step |=> $stable(state), "bank state changed without a write")
  `CBC_ASSERT(a_pending_kept, clk, rst, (in_vld && !advance) |=> in_vld, "held write was dropped")
  `CBC_ASSERT(a_flush_needs_enable, clk, rst, (step && flush) |-> (state.ram_en && !state_next.ram_en), "flush without falling enable")
  `CBC_ASSERT(a_result_follows_step, clk, rst, step |=> out_vld, "decoded write produced no result")
  `CBC_ASSERT_ALWAYS(a_reset_clears, clk, rst |=> (!in_vld && !out_vld), "reset left an item in flight")

endmodule

@@ rtl/cbc_apb_regs.sv @@
// ----------------------------------------------------------------------------
// Cartridge bank controller register file
// APB-style slave holding the controller kind register.
// ----------------------------------------------------------------------------
module cbc_apb_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cbc_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [cbc_pkg::APB_DATA_W-1:0] pwdata,
  output logic [cbc_pkg::APB_DATA_W-1:0] prdata,
  output logic                          pready,
  output logic [cbc_pkg::KIND_W-1:0]     kind
);
  import cbc_pkg::*;

  logic reg_index;
  logic wr_en;

  // Registers sit on 4-byte boundaries; the low two address bits are ignored.
  assign reg_index = paddr[APB_ADDR_W-1];
  assign pready    = 1'b1;
  assign wr_en     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      kind <= KIND_NONE;
    end else if (wr_en && reg_index == REG_KIND) begin
      kind <= pwdata[KIND_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_index == REG_KIND) begin
      prdata = {{(APB_DATA_W-KIND_W){1'b0}}, kind};
    end
  end

endmodule

@@ rtl/cbc_decode.sv @@
// ----------------------------------------------------------------------------
// Cartridge bank controller write decoder
// Next bank state and RAM flush for one ROM-window write.
// ----------------------------------------------------------------------------
module cbc_decode (
  input  logic [cbc_pkg::KIND_W-1:0] kind,
  input  logic [cbc_pkg::ADDR_W-1:0] addr,
  input  logic [cbc_pkg::DATA_W-1:0] data,
  input  cbc_pkg::cbc_state_t        state,
  output cbc_pkg::cbc_state_t        state_next,
  output logic                       flush
);
  import cbc_pkg::*;

  logic [1:0] region;
  logic       key_ok;
  logic [4:0] low5;
  logic [3:0] low4;
  logic [6:0] low7;

  assign region = addr[ADDR_W-1:ADDR_W-2];
  assign key_ok = (data[3:0] == RAM_ENABLE_KEY);
  // A bank field of zero selects bank one on MBC1, MBC2 and MBC3.
  assign low5   = (data[4:0] == 5'd0) ? 5'd1 : data[4:0];
  assign low4   = (data[3:0] == 4'd0) ? 4'd1 : data[3:0];
  assign low7   = (data[6:0] == 7'd0) ? 7'd1 : data[6:0];

  always_comb begin
    state_next = state;
    flush      = 1'b0;
    case (kind)
      KIND_MBC1: begin
        // MBC1 only has a 7-bit ROM bank, so bits 8:7 are cleared on any ROM bank write.
        case (region)
          REGION_ENABLE: state_next.ram_en = key_ok;
          REGION_ROM:    state_next.rom_bank = {2'b00, state.rom_bank[6:5], low5};
          REGION_HIGH: begin
            if (!state.mode) begin
              state_next.rom_bank = {2'b00, data[1:0], state.rom_bank[4:0]};
            end else begin
              state_next.ram_bank = {2'b00, data[1:0]};
            end
          end
          REGION_MODE:   state_next.mode = data[0];
          default:       state_next = state;
        endcase
      end
      KIND_MBC2: begin
        case (region)
          REGION_ENABLE: begin
            if (!addr[8]) begin
              state_next.ram_en = key_ok;
            end
          end
          REGION_ROM:    state_next.rom_bank = {5'd0, low4};
          default:       state_next = state;
        endcase
      end
      KIND_MBC3: begin
        case (region)
          REGION_ENABLE: state_next.ram_en = key_ok;
          REGION_ROM:    state_next.rom_bank = {2'b00, low7};
          REGION_HIGH: begin
            if (data[7:2] == 6'd0) begin
              state_next.ram_bank = {2'b00, data[1:0]};
            end
          end
          REGION_MODE: begin
            // Writing 0 then 1 toggles the clock latch.
            if (data == LATCH_ARM) begin
              state_next.armed = 1'b1;
            end else begin
              if (data == LATCH_FIRE && state.armed) begin
                state_next.latched = !state.latched;
              end
              state_next.armed = 1'b0;
            end
          end
          default:       state_next = state;
        endcase
      end
      KIND_MBC5: begin
        case (region)
          REGION_ENABLE: state_next.ram_en = key_ok;
          REGION_ROM: begin
            if (!addr[12]) begin
              state_next.rom_bank = {state.rom_bank[8], data};
            end else begin
              state_next.rom_bank = {data[0], state.rom_bank[7:0]};
            end
          end
          REGION_HIGH:   state_next.ram_bank = data[3:0];
          default:       state_next = state;
        endcase
      end
      default: state_next = state;
    endcase
    flush = state.ram_en && !state_next.ram_en;
  end

endmodule

@@ bench/testbench.sv @@
// ----------------------------------------------------------------------------
// Cartridge bank controller testbench
// Streams CPU writes to the ROM window under every controller kind and
// compares each bank status transaction with an in-bench model of the bank
// registers. Both channels idle at random, and the kind register is changed
// over APB between phases while the block is idle.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import cbc_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int PHASE_WRITES = 85;
  localparam int MAX_REPORTS  = 10;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
  } cpu_write_t;

  typedef struct packed {
    logic [ROM_BANK_W-1:0] rom_bank;
    logic [RAM_BANK_W-1:0] ram_bank;
    logic                  ram_en;
    logic                  mode;
    logic                  latched;
    logic                  flush;
  } bank_status_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  wr_valid = 1'b0;
  logic [ADDR_W-1:0]     wr_addr  = '0;
  logic [DATA_W-1:0]     wr_byte  = '0;
  logic                  res_take = 1'b0;

  logic                  psel    = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite  = 1'b0;
  logic [APB_ADDR_W-1:0] paddr   = '0;
  logic [APB_DATA_W-1:0] pwdata  = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  cbc_wr_if  wr_ch ();
  cbc_res_if res_ch ();

  assign wr_ch.valid         = wr_valid;
  assign wr_ch.write_address = wr_addr;
  assign wr_ch.write_data    = wr_byte;
  assign res_ch.ready        = res_take;

  cartridge_bank_controller_core dut (
    .clk     (clk),
    .rst     (rst),
    .wr      (wr_ch),
    .res     (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #6 clk = ~clk;

  cpu_write_t   cpu_writes [$];
  bank_status_t pending_status [$];

  cbc_state_t        bank = STATE_RESET;
  logic [KIND_W-1:0] kind_shadow = KIND_NONE;

  bit calm = 1'b0;
  int send_gap = 0;
  int hold_cnt = 0;
  int mismatches = 0;
  int cycles = 0;

  logic [KIND_W-1:0] phase_kinds [10] = '{KIND_MBC1, KIND_MBC3, KIND_MBC5, KIND_MBC2,
                                          KIND_NONE, KIND_MBC3, KIND_MBC1, KIND_MBC5,
                                          KIND_MBC3, KIND_MBC2};

  // Idle length for either side: mostly none or short, now and then long.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (calm) return 0;
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Applies one CPU write to the bank registers and returns the status after it.
  function automatic bank_status_t bank_update(logic [ADDR_W-1:0] a, logic [DATA_W-1:0] d);
    bank_status_t s;
    logic         was_en;
    logic [4:0]   lo5;
    logic [6:0]   lo7;
    logic [3:0]   lo4;
    was_en = bank.ram_en;
    lo5 = (d[4:0] == 5'd0) ? 5'd1 : d[4:0];
    lo7 = (d[6:0] == 7'd0) ? 7'd1 : d[6:0];
    lo4 = (d[3:0] == 4'd0) ? 4'd1 : d[3:0];
    case (kind_shadow)
      KIND_MBC1: begin
        case (a[14:13])
          REGION_ENABLE: bank.ram_en = (d[3:0] == RAM_ENABLE_KEY);
          REGION_ROM:    bank.rom_bank = {2'b00, bank.rom_bank[6:5], lo5};
          REGION_HIGH: begin
            if (!bank.mode) bank.rom_bank = {2'b00, d[1:0], bank.rom_bank[4:0]};
            else bank.ram_bank = {2'b00, d[1:0]};
          end
          default:       bank.mode = d[0];
        endcase
      end
      KIND_MBC2: begin
        // Address bit 8 steers a write away from the RAM enable.
        if (a[14:13] == REGION_ENABLE && !a[8]) bank.ram_en = (d[3:0] == RAM_ENABLE_KEY);
        else if (a[14:13] == REGION_ROM) bank.rom_bank = {5'd0, lo4};
      end
      KIND_MBC3: begin
        case (a[14:13])
          REGION_ENABLE: bank.ram_en = (d[3:0] == RAM_ENABLE_KEY);
          REGION_ROM:    bank.rom_bank = {2'b00, lo7};
          REGION_HIGH: begin
            // Clock register selects and other values keep the RAM bank.
            if (d <= 8'd3) bank.ram_bank = d[3:0];
          end
          default: begin
            if (d == LATCH_ARM) begin
              bank.armed = 1'b1;
            end else if (d == LATCH_FIRE) begin
              if (bank.armed) bank.latched = ~bank.latched;
              bank.armed = 1'b0;
            end else begin
              bank.armed = 1'b0;
            end
          end
        endcase
      end
      KIND_MBC5: begin
        case (a[14:13])
          REGION_ENABLE: bank.ram_en = (d[3:0] == RAM_ENABLE_KEY);
          REGION_ROM: begin
            if (!a[12]) bank.rom_bank = {bank.rom_bank[8], d};
            else bank.rom_bank = {d[0], bank.rom_bank[7:0]};
          end
          REGION_HIGH:   bank.ram_bank = d[3:0];
          default: ;
        endcase
      end
      default: ;
    endcase
    s.rom_bank = bank.rom_bank;
    s.ram_bank = bank.ram_bank;
    s.ram_en   = bank.ram_en;
    s.mode     = bank.mode;
    s.latched  = bank.latched;
    s.flush    = was_en && !bank.ram_en;
    return s;
  endfunction

  // Write driver: holds a write until it is taken, then idles for a random gap.
  always @(posedge clk) begin
    if (rst) begin
      wr_valid <= 1'b0;
    end else begin : drive_writes
      cpu_write_t item;
      if (wr_valid && wr_ch.ready)
        pending_status.push_back(bank_update(wr_addr, wr_byte));
      if (wr_valid && !wr_ch.ready) begin
        wr_valid <= 1'b1;
      end else if (send_gap != 0) begin
        send_gap <= send_gap - 1;
        wr_valid <= 1'b0;
      end else if (cpu_writes.size() != 0) begin
        item = cpu_writes.pop_front();
        wr_addr  <= item.addr;
        wr_byte  <= item.data;
        wr_valid <= 1'b1;
        send_gap <= idle_len();
      end else begin
        wr_valid <= 1'b0;
      end
    end
  end

  // Status monitor with random back-pressure.
  always @(posedge clk) begin : check_status
    bank_status_t got;
    bank_status_t want;
    if (!rst && res_ch.valid && res_take) begin
      got.rom_bank = res_ch.rom_bank_now;
      got.ram_bank = res_ch.ram_bank_now;
      got.ram_en   = res_ch.ram_enabled;
      got.mode     = res_ch.banking_mode;
      got.latched  = res_ch.clock_latched;
      got.flush    = res_ch.ram_flush;
      if (pending_status.size() == 0) begin
        if (mismatches < MAX_REPORTS)
          $display("unexpected status transaction: rom %0d ram %0d en %b mode %b latch %b flush %b",
                   got.rom_bank, got.ram_bank, got.ram_en, got.mode, got.latched, got.flush);
        mismatches++;
      end else begin
        want = pending_status.pop_front();
        if (got.rom_bank !== want.rom_bank || got.ram_bank !== want.ram_bank ||
            got.ram_en !== want.ram_en || got.mode !== want.mode ||
            got.latched !== want.latched || got.flush !== want.flush) begin
          if (mismatches < MAX_REPORTS) begin
            $display("status mismatch at cycle %0d", cycles);
            $display("  expected rom %0d ram %0d en %b mode %b latch %b flush %b",
                     want.rom_bank, want.ram_bank, want.ram_en, want.mode,
                     want.latched, want.flush);
            $display("  actual   rom %0d ram %0d en %b mode %b latch %b flush %b",
                     got.rom_bank, got.ram_bank, got.ram_en, got.mode,
                     got.latched, got.flush);
          end
          mismatches++;
        end
      end
    end
    if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
      res_take <= 1'b0;
    end else begin
      res_take <= 1'b1;
      hold_cnt <= ($urandom_range(0, 3) == 0) ? idle_len() : 0;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic push_write(input logic [ADDR_W-1:0] a, input logic [DATA_W-1:0] d);
    cpu_write_t item;
    item.addr = a;
    item.data = d;
    cpu_writes.push_back(item);
  endtask

  // Waits until every queued write has been sent and its status has arrived.
  task automatic settle();
    do @(negedge clk); while (cpu_writes.size() != 0 || wr_valid || pending_status.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_kind(input logic [KIND_W-1:0] k);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_ADDR_W'(4 * REG_KIND);
    pwdata  <= APB_DATA_W'(k);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    kind_shadow = k;
  endtask

  task automatic queue_random_writes(input int count);
    int                n;
    logic [1:0]        region;
    logic [ADDR_W-1:0] a;
    logic [DATA_W-1:0] d;
    n = 0;
    while (n < count) begin
      region = 2'($urandom_range(0, 3));
      a = {region, 13'($urandom)};
      if ($urandom_range(0, 9) == 0) begin
        // Clock latch sequence: arm, then fire.
        push_write({REGION_MODE, 13'($urandom)}, LATCH_ARM);
        push_write({REGION_MODE, 13'($urandom)}, LATCH_FIRE);
        n += 2;
      end else begin
        case ($urandom_range(0, 9))
          0: d = {4'($urandom), RAM_ENABLE_KEY};
          1: d = LATCH_ARM;
          2: d = LATCH_FIRE;
          3: d = 8'($urandom_range(0, 3));
          4: d = 8'($urandom_range(8, 12));
          default: d = 8'($urandom);
        endcase
        push_write(a, d);
        n++;
      end
    end
  endtask

  initial begin : run_phases
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // MBC1: zero bank fix-up, upper ROM bits, RAM mode and a flush.
    write_kind(KIND_MBC1);
    push_write(15'h0000, 8'h0A);
    push_write(15'h2000, 8'h00);
    push_write(15'h3FFF, 8'hFF);
    push_write(15'h4000, 8'h03);
    push_write(15'h6000, 8'h01);
    push_write(15'h5FFF, 8'hFF);
    push_write(15'h1FFF, 8'h00);
    settle();

    // MBC2: address bit 8 blocks the enable, the ROM region sets the bank, other regions are ignored.
    write_kind(KIND_MBC2);
    push_write(15'h0100, 8'h0A);
    push_write(15'h00FF, 8'hFA);
    push_write(15'h2000, 8'h00);
    push_write(15'h4000, 8'h55);
    push_write(15'h0000, 8'h0B);
    settle();

    // MBC3: clock select leaves the RAM bank, latch toggles only when armed.
    write_kind(KIND_MBC3);
    push_write(15'h3FFF, 8'h80);
    push_write(15'h4000, 8'h03);
    push_write(15'h4000, 8'h08);
    push_write(15'h6000, 8'h00);
    push_write(15'h7FFF, 8'h01);
    push_write(15'h6000, 8'h01);
    push_write(15'h6000, 8'h00);
    push_write(15'h6000, 8'h02);
    push_write(15'h6000, 8'h01);
    settle();

    // MBC5: bank 0 is legal, bit 8 from the upper half, mode region ignored.
    write_kind(KIND_MBC5);
    push_write(15'h2000, 8'h00);
    push_write(15'h2FFF, 8'hFF);
    push_write(15'h3000, 8'h01);
    push_write(15'h5FFF, 8'hFF);
    push_write(15'h7FFF, 8'hFF);
    settle();

    // No controller: nothing changes.
    write_kind(KIND_NONE);
    push_write(15'h2000, 8'h05);
    settle();

    for (int p = 0; p < 10; p++) begin
      calm = (p == 2 || p == 6);
      write_kind(phase_kinds[p]);
      queue_random_writes(PHASE_WRITES);
      settle();
    end

    repeat (8) @(posedge clk);
    if (mismatches == 0 && pending_status.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl
rtl/cbc_pkg.sv
rtl/cbc_channels.sv
rtl/cbc_apb_regs.sv
rtl/cbc_decode.sv
rtl/cartridge_bank_controller_core.sv
bench/testbench.sv
